FILE: hdl/bsr_pkg.sv
// Shared types, constants and helpers for the byte stream reassembler.
package bsr_pkg;

  localparam int DEF_RING_DEPTH = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int RUN_W          = $clog2(MAX_RESULTS);
  localparam int IDX_W          = 64;
  localparam int BYTE_W         = 8;
  localparam int ROOM_IN_W      = 6;
  localparam int ROOM_W         = 7;
  localparam int PEND_W         = 6;
  localparam int PEND_MAX       = 63;

  // Classified item handed from the front to the back through the queue
  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              has_byte;
    logic              segment_end;
    logic              stream_end;
    logic [ROOM_W-1:0] room;       // clamped to the ring depth
    logic [IDX_W-1:0]  end_index;  // candidate end-of-stream index
  } bsr_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } bsr_state_t;

  function automatic logic [PEND_W-1:0] pend_sat(input int unsigned p);
    logic [PEND_W-1:0] r;
    if (p > PEND_MAX) r = PEND_W'(PEND_MAX);
    else r = PEND_W'(p);
    return r;
  endfunction

endpackage

FILE: hdl/bsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/bsr_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
module bsr_front #(
  parameter int RING_DEPTH = bsr_pkg::DEF_RING_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bsr_pkg::IDX_W-1:0]       in_byte_index,
  input  logic [bsr_pkg::BYTE_W-1:0]      in_byte_value,
  input  logic                            in_has_byte,
  input  logic                            in_segment_end,
  input  logic                            in_stream_end,
  input  logic [bsr_pkg::ROOM_IN_W-1:0]   in_window_room,
  output logic                            q_valid,
  output bsr_pkg::bsr_item_t              q_item,
  input  logic                            q_pop
);
  import bsr_pkg::*;

  bsr_item_t   mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  bsr_item_t   item;
  logic [ROOM_W-1:0] room_ext;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    room_ext         = {1'b0, in_window_room};
    item.byte_index  = in_byte_index;
    item.byte_value  = in_byte_value;
    item.has_byte    = in_has_byte;
    item.segment_end = in_segment_end;
    item.stream_end  = in_stream_end;
    item.room        = (room_ext > ROOM_W'(RING_DEPTH)) ? ROOM_W'(RING_DEPTH) : room_ext;
    item.end_index   = in_byte_index + IDX_W'(in_has_byte);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_valid);
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |=> (cnt_r == 2'd0) || (cnt_r == 2'd1))
    else $error("queue grew by more than one entry");

endmodule

FILE: hdl/bsr_back.sv
// Back end: stores bytes in the ring, drains the in-order run and drives the result register.
module bsr_back #(
  parameter int RING_DEPTH = bsr_pkg::DEF_RING_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  bsr_pkg::bsr_item_t                 q_item,
  output logic                               q_pop,
  output logic                               ram_we,
  output logic [$clog2(RING_DEPTH)-1:0]      ram_waddr,
  output logic [bsr_pkg::BYTE_W-1:0]         ram_wdata,
  output logic [$clog2(RING_DEPTH)-1:0]      ram_raddr,
  input  logic [bsr_pkg::BYTE_W-1:0]         ram_rdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bsr_pkg::BYTE_W-1:0]         out_out_byte,
  output logic                               out_out_valid,
  output logic                               out_run_last,
  output logic                               out_stream_closed,
  output logic [bsr_pkg::PEND_W-1:0]         out_pending_bytes
);
  import bsr_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int SUM_W  = SLOT_W + 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);

  bsr_state_t              state_r, state_nxt;
  logic [IDX_W-1:0]        ne_r, ne_nxt;
  logic [SLOT_W-1:0]       ne_slot_r, ne_slot_nxt;
  logic [CNT_W-1:0]        pend_r, pend_nxt;
  logic [IDX_W-1:0]        end_idx_r, end_idx_nxt;
  logic                    end_known_r, end_known_nxt;
  logic                    closed_r, closed_nxt;
  logic [RING_DEPTH-1:0]   valid_r, valid_nxt;
  logic [RUN_W-1:0]        n_r, n_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]       out_byte_r, out_byte_nxt;
  logic                    out_bval_r, out_bval_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_closed_r, out_closed_nxt;
  logic [PEND_W-1:0]       out_pend_r, out_pend_nxt;

  logic [IDX_W-1:0]        diff;
  logic                    in_win;
  logic [SUM_W-1:0]        slot_sum;
  logic [SLOT_W-1:0]       wslot;
  logic [SLOT_W-1:0]       inc_slot;
  logic [IDX_W-1:0]        ne_inc;
  logic [CNT_W-1:0]        pend_dec;
  logic                    out_free;
  logic                    last;
  logic                    closed_fin;

  assign ram_raddr = ne_slot_r;
  assign ram_waddr = wslot;
  assign ram_wdata = q_item.byte_value;

  always_comb begin
    state_nxt      = state_r;
    ne_nxt         = ne_r;
    ne_slot_nxt    = ne_slot_r;
    pend_nxt       = pend_r;
    end_idx_nxt    = end_idx_r;
    end_known_nxt  = end_known_r;
    closed_nxt     = closed_r;
    valid_nxt      = valid_r;
    n_nxt          = n_r;
    out_free       = !out_valid_r || !out_stall;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_bval_nxt   = out_bval_r;
    out_last_nxt   = out_last_r;
    out_closed_nxt = out_closed_r;
    out_pend_nxt   = out_pend_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    last           = 1'b0;
    closed_fin     = closed_r;

    // Window test and slot of the incoming byte, relative to the ring head
    diff     = q_item.byte_index - ne_r;
    in_win   = q_item.has_byte && (q_item.byte_index >= ne_r) &&
               (diff < IDX_W'(q_item.room));
    slot_sum = {1'b0, ne_slot_r} + {1'b0, diff[SLOT_W-1:0]};
    wslot    = (slot_sum >= SUM_W'(RING_DEPTH)) ?
               SLOT_W'(slot_sum - SUM_W'(RING_DEPTH)) : slot_sum[SLOT_W-1:0];
    inc_slot = (ne_slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : ne_slot_r + 1'b1;
    ne_inc   = ne_r + 1'b1;
    pend_dec = pend_r - 1'b1;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (in_win) begin
            ram_we           = 1'b1;
            valid_nxt[wslot] = 1'b1;
            if (!valid_r[wslot]) begin
              pend_nxt = pend_r + 1'b1;
            end
          end
          if (q_item.segment_end) begin
            if (q_item.stream_end) begin
              end_known_nxt = 1'b1;
              end_idx_nxt   = q_item.end_index;
            end
            n_nxt     = '0;
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ: begin
        // RAM address is the head slot; data is ready next cycle
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          if (valid_r[ne_slot_r]) begin
            last       = !valid_r[inc_slot] || (n_r == RUN_W'(MAX_RESULTS - 1));
            closed_fin = closed_r || (end_known_r && (ne_inc == end_idx_r));
            valid_nxt[ne_slot_r] = 1'b0;
            pend_nxt       = pend_dec;
            ne_nxt         = ne_inc;
            ne_slot_nxt    = inc_slot;
            n_nxt          = n_r + 1'b1;
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = ram_rdata;
            out_bval_nxt   = 1'b1;
            out_last_nxt   = last;
            out_closed_nxt = last ? closed_fin : closed_r;
            out_pend_nxt   = pend_sat(32'(pend_dec));
            if (last) begin
              closed_nxt = closed_fin;
              state_nxt  = BK_IDLE;
            end else begin
              state_nxt  = BK_READ;
            end
          end else begin
            // nothing to deliver: one empty result
            closed_fin     = closed_r || (end_known_r && (ne_r == end_idx_r));
            closed_nxt     = closed_fin;
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = '0;
            out_bval_nxt   = 1'b0;
            out_last_nxt   = 1'b1;
            out_closed_nxt = closed_fin;
            out_pend_nxt   = pend_sat(32'(pend_r));
            state_nxt      = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      ne_r        <= '0;
      ne_slot_r   <= '0;
      pend_r      <= '0;
      end_idx_r   <= '0;
      end_known_r <= 1'b0;
      closed_r    <= 1'b0;
      valid_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      ne_slot_r   <= ne_slot_nxt;
      pend_r      <= pend_nxt;
      end_idx_r   <= end_idx_nxt;
      end_known_r <= end_known_nxt;
      closed_r    <= closed_nxt;
      valid_r     <= valid_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_bval_r   <= out_bval_nxt;
    out_last_r   <= out_last_nxt;
    out_closed_r <= out_closed_nxt;
    out_pend_r   <= out_pend_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_out_byte      = out_byte_r;
  assign out_out_valid     = out_bval_r;
  assign out_run_last      = out_last_r;
  assign out_stream_closed = out_closed_r;
  assign out_pending_bytes = out_pend_r;

  a_pend_matches_tags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(pend_r)) else $error("pending count disagrees with tags");

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r) else $error("closed flag dropped");

  a_head_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    ne_slot_r <= SLOT_W'(RING_DEPTH - 1)) else $error("head slot out of range");

  a_no_pop_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !q_pop) else $error("queue popped during drain");

endmodule

FILE: hdl/byte_stream_reassembler_top.sv
// Top level of the byte stream reassembler: front queue, back end and slot RAM.
// Back end: takes one item per cycle while idle; a segment end then drains the in-order
// run (registered slot RAM read, then result), or gives one empty result if none drains.
// A byte passes the front queue, the idle, read and emit states and the result register.
// No item is popped while a run drains; the drain waits while the output is stalled.
// Reset is synchronous, active low; slot tags clear together at reset, no clearing pass.
module byte_stream_reassembler_top #(
  parameter int RING_DEPTH = bsr_pkg::DEF_RING_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bsr_pkg::IDX_W-1:0]       in_byte_index,
  input  logic [bsr_pkg::BYTE_W-1:0]      in_byte_value,
  input  logic                            in_has_byte,
  input  logic                            in_segment_end,
  input  logic                            in_stream_end,
  input  logic [bsr_pkg::ROOM_IN_W-1:0]   in_window_room,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bsr_pkg::BYTE_W-1:0]      out_out_byte,
  output logic                            out_out_valid,
  output logic                            out_run_last,
  output logic                            out_stream_closed,
  output logic [bsr_pkg::PEND_W-1:0]      out_pending_bytes
);
  import bsr_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);

  logic              q_valid;
  bsr_item_t         q_item;
  logic              q_pop;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  bsr_front #(.RING_DEPTH(RING_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_index  (in_byte_index),
    .in_byte_value  (in_byte_value),
    .in_has_byte    (in_has_byte),
    .in_segment_end (in_segment_end),
    .in_stream_end  (in_stream_end),
    .in_window_room (in_window_room),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  bsr_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bsr_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_out_valid     (out_out_valid),
    .out_run_last      (out_run_last),
    .out_stream_closed (out_stream_closed),
    .out_pending_bytes (out_pending_bytes)
  );

endmodule

FILE: dv/tb_byte_stream_reassembler_top.sv
// Self-checking testbench for the byte stream reassembler: directed and random substrings.
module tb_byte_stream_reassembler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsr_pkg::*;

  localparam int RING_DEPTH   = DEF_RING_DEPTH;
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 170;
  localparam int TAIL_CYCLES  = 200;
  localparam int LIMIT_NS     = 5_000_000;

  typedef struct {
    logic [IDX_W-1:0]     idx;
    logic [BYTE_W-1:0]    data;
    logic                 has;
    logic                 seg;
    logic                 fin;
    logic [ROOM_IN_W-1:0] room;
  } stream_item_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              vld;
    logic              run_end;
    logic              closed;
    logic [PEND_W-1:0] pend;
  } delivery_t;

  typedef enum {ST_NONE, ST_HALF, ST_QUARTER, ST_BLOCK} stall_pat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [IDX_W-1:0]     in_byte_index = '0;
  logic [BYTE_W-1:0]    in_byte_value = '0;
  logic                 in_has_byte = 1'b0;
  logic                 in_segment_end = 1'b0;
  logic                 in_stream_end = 1'b0;
  logic [ROOM_IN_W-1:0] in_window_room = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_out_byte;
  logic                 out_out_valid;
  logic                 out_run_last;
  logic                 out_stream_closed;
  logic [PEND_W-1:0]    out_pending_bytes;

  // reassembly state mirrored from the accepted transactions
  bit                slot_vld [RING_DEPTH];
  logic [BYTE_W-1:0] slot_dat [RING_DEPTH];
  logic [IDX_W-1:0]  next_exp = '0;
  int                pend_cnt = 0;
  logic [IDX_W-1:0]  end_idx = '0;
  bit                end_known = 1'b0;
  bit                closed_st = 1'b0;

  delivery_t delivery_q[$];
  delivery_t exp_d;
  int        errors = 0;
  int        items_sent = 0;
  bit        idle_on = 1'b1;
  int        burst_left = 0;
  int        hold_reqs = 0;

  // receiver-side state, written only by the stall process
  int         hold_seen = 0;
  int         hold_left = 0;
  int         pat_left = 0;
  stall_pat_t pat_mode = ST_NONE;

  byte_stream_reassembler_top #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_index    (in_byte_index),
    .in_byte_value    (in_byte_value),
    .in_has_byte      (in_has_byte),
    .in_segment_end   (in_segment_end),
    .in_stream_end    (in_stream_end),
    .in_window_room   (in_window_room),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_byte     (out_out_byte),
    .out_out_valid    (out_out_valid),
    .out_run_last     (out_run_last),
    .out_stream_closed(out_stream_closed),
    .out_pending_bytes(out_pending_bytes)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic stream_item_t make_item(input logic [IDX_W-1:0] idx,
                                             input logic [BYTE_W-1:0] data,
                                             input logic has, input logic seg,
                                             input logic fin,
                                             input logic [ROOM_IN_W-1:0] room);
    stream_item_t it;
    it.idx  = idx;
    it.data = data;
    it.has  = has;
    it.seg  = seg;
    it.fin  = fin;
    it.room = room;
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Store the byte if it falls in the window; on a segment end, drain the in-order run.
  task automatic reassemble(input stream_item_t it);
    int unsigned win;
    int          s;
    int          n;
    bit          closed_before;
    logic [IDX_W-1:0] off;
    delivery_t   d;
    win = (it.room > RING_DEPTH) ? RING_DEPTH : it.room;
    closed_before = closed_st;
    off = it.idx - next_exp;
    if (it.has && it.idx >= next_exp && off < win) begin
      s = int'(it.idx % RING_DEPTH);
      if (!slot_vld[s]) pend_cnt++;
      slot_vld[s] = 1'b1;
      slot_dat[s] = it.data;
    end
    if (!it.seg) return;
    if (it.fin) begin
      end_known = 1'b1;
      end_idx = it.idx + IDX_W'(it.has);
    end
    n = 0;
    while (n < MAX_RESULTS && slot_vld[int'(next_exp % RING_DEPTH)]) begin
      s = int'(next_exp % RING_DEPTH);
      d.data = slot_dat[s];
      slot_vld[s] = 1'b0;
      pend_cnt--;
      next_exp++;
      d.vld = 1'b1;
      d.run_end = 1'b0;
      d.closed = closed_before;
      d.pend = pend_sat(pend_cnt);
      delivery_q.insert(delivery_q.size(), d);
      n++;
    end
    if (end_known && next_exp == end_idx) closed_st = 1'b1;
    if (n == 0) begin
      d.data = '0;
      d.vld = 1'b0;
      d.run_end = 1'b1;
      d.closed = closed_st;
      d.pend = pend_sat(pend_cnt);
      delivery_q.insert(delivery_q.size(), d);
    end else begin
      delivery_q[delivery_q.size() - 1].run_end = 1'b1;
      delivery_q[delivery_q.size() - 1].closed = closed_st;
    end
  endtask

  // Entered and left at a rising edge; the last edge is the one that accepts the transaction.
  task automatic send_item(input stream_item_t it);
    int gap;
    bit taken;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid       <= 1'b1;
    in_byte_index  <= it.idx;
    in_byte_value  <= it.data;
    in_has_byte    <= it.has;
    in_segment_end <= it.seg;
    in_stream_end  <= it.fin;
    in_window_room <= it.room;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    reassemble(it);
    if (it.has || it.seg) items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (delivery_q.size() != 0);
  endtask

  // Bytes at next+31 down to next+1, then next with segment end: the whole ring drains.
  task automatic fill_window();
    logic [IDX_W-1:0] base;
    base = next_exp;
    for (int k = RING_DEPTH - 1; k >= 0; k--)
      send_item(make_item(base + k, 8'($urandom), 1'b1, k == 0, 1'b0, 6'(RING_DEPTH)));
  endtask

  task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
    if (a !== e) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (delivery_q.size() == 0) begin
        $display("%0t unexpected result byte %0h valid %0b", $time, out_out_byte,
                 out_out_valid);
        errors++;
      end else begin
        exp_d = delivery_q.pop_front();
        check_field("out_byte", exp_d.data, out_out_byte);
        check_field("out_valid", 8'(exp_d.vld), 8'(out_out_valid));
        check_field("run_last", 8'(exp_d.run_end), 8'(out_run_last));
        check_field("stream_closed", 8'(exp_d.closed), 8'(out_stream_closed));
        check_field("pending_bytes", 8'(exp_d.pend), 8'(out_pending_bytes));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_mode = stall_pat_t'($urandom_range(0, 3));
        pat_left = $urandom_range(4, 40);
      end
      pat_left--;
      case (pat_mode)
        ST_NONE:    out_stall <= 1'b0;
        ST_HALF:    out_stall <= ($urandom_range(0, 1) == 0);
        ST_QUARTER: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= (pat_left < 6);
      endcase
    end
  end

  task automatic test_empty_segment();
    send_item(make_item('0, 8'h00, 1'b0, 1'b1, 1'b0, 6'd32));
    send_item(make_item('1, 8'hff, 1'b0, 1'b1, 1'b0, 6'd63));
  endtask

  task automatic test_in_order();
    logic [IDX_W-1:0] n;
    n = next_exp;
    send_item(make_item(n, 8'h00, 1'b1, 1'b0, 1'b0, 6'd32));
    send_item(make_item(n + 1, 8'hff, 1'b1, 1'b1, 1'b0, 6'd32));
    send_item(make_item(n + 2, 8'ha5, 1'b1, 1'b1, 1'b0, 6'd32));
  endtask

  task automatic test_out_of_order();
    logic [IDX_W-1:0] n;
    n = next_exp;
    send_item(make_item(n + 2, 8'h5a, 1'b1, 1'b0, 1'b0, 6'd16));
    send_item(make_item(n + 3, 8'h3c, 1'b1, 1'b1, 1'b0, 6'd16));
    send_item(make_item(n + 1, 8'hc3, 1'b1, 1'b1, 1'b0, 6'd16));
    send_item(make_item(n, 8'h81, 1'b1, 1'b1, 1'b0, 6'd16));
  endtask

  task automatic test_window_edges();
    logic [IDX_W-1:0] n;
    n = next_exp;
    send_item(make_item(n, 8'h11, 1'b1, 1'b1, 1'b0, 6'd0));
    // one past the window is dropped, the last slot inside it is kept
    send_item(make_item(n + 4, 8'h22, 1'b1, 1'b1, 1'b0, 6'd4));
    send_item(make_item(n + 3, 8'h33, 1'b1, 1'b1, 1'b0, 6'd4));
    send_item(make_item(n - 1, 8'h44, 1'b1, 1'b1, 1'b0, 6'd32));
    // room above the ring depth clamps to it
    send_item(make_item(n + RING_DEPTH - 1, 8'h55, 1'b1, 1'b0, 1'b0, 6'd63));
    send_item(make_item(n + RING_DEPTH, 8'h66, 1'b1, 1'b0, 1'b0, 6'd63));
    send_item(make_item(n, 8'h77, 1'b1, 1'b0, 1'b0, 6'd40));
    send_item(make_item(n + 1, 8'h88, 1'b1, 1'b0, 1'b0, 6'd40));
    send_item(make_item(n + 2, 8'h99, 1'b1, 1'b1, 1'b0, 6'd40));
  endtask

  task automatic test_overwrite();
    logic [IDX_W-1:0] n;
    n = next_exp;
    send_item(make_item(n, 8'h12, 1'b1, 1'b0, 1'b0, 6'd8));
    send_item(make_item(n, 8'h34, 1'b1, 1'b0, 1'b0, 6'd8));
    send_item(make_item(n, 8'h00, 1'b0, 1'b1, 1'b0, 6'd8));
  endtask

  task automatic test_full_ring();
    fill_window();
    wait_drain();
  endtask

  task automatic test_backpressure();
    logic [IDX_W-1:0] base;
    hold_reqs++;
    for (int c = 0; c < 5; c++) begin
      base = next_exp;
      for (int k = 0; k < 24; k++)
        send_item(make_item(base + k, 8'($urandom), 1'b1, k == 23, 1'b0, 6'd32));
    end
    wait_drain();
  endtask

  // A stretch of the stream split into substrings that arrive shuffled.
  task automatic send_chunk(input logic [ROOM_IN_W-1:0] room);
    int win;
    int len;
    int np;
    int cut;
    int t;
    int tmp;
    int off;
    int pst[4];
    int pln[4];
    bit rev;
    bit noseg;
    logic [IDX_W-1:0] base;
    win = (room > RING_DEPTH) ? RING_DEPTH : room;
    base = next_exp;
    if (win == 0) begin
      send_item(make_item(base, 8'($urandom), 1'b1, 1'b1, 1'b0, room));
      return;
    end
    len = $urandom_range(1, win);
    np = $urandom_range(1, (len < 4) ? len : 4);
    cut = 0;
    for (int p = 0; p < np; p++) begin
      pst[p] = cut;
      pln[p] = (p == np - 1) ? len - cut : $urandom_range(1, len - cut - (np - 1 - p));
      cut += pln[p];
    end
    for (int p = np - 1; p > 0; p--) begin
      t = $urandom_range(0, p);
      tmp = pst[p]; pst[p] = pst[t]; pst[t] = tmp;
      tmp = pln[p]; pln[p] = pln[t]; pln[t] = tmp;
    end
    for (int p = 0; p < np; p++) begin
      rev = ($urandom_range(0, 3) == 0);
      noseg = ($urandom_range(0, 19) == 0);
      for (int k = 0; k < pln[p]; k++) begin
        off = rev ? pst[p] + pln[p] - 1 - k : pst[p] + k;
        send_item(make_item(base + off, 8'($urandom), 1'b1, (k == pln[p] - 1) && !noseg,
                            1'b0, room));
      end
    end
  endtask

  task automatic test_random_streams();
    int sel;
    int r;
    bit seg;
    logic [IDX_W-1:0] n;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_chunk(6'($urandom_range(8, 32)));
        else if (r < 85) send_chunk(6'($urandom_range(33, 63)));
        else send_chunk(6'($urandom_range(0, 7)));
      end else if (sel < 80) begin
        seg = 1'($urandom);
        send_item(make_item(rand64(), 8'($urandom), 1'b1, seg, seg ? 1'b0 : 1'($urandom),
                            6'($urandom)));
      end else if (sel < 87) begin
        send_item(make_item($urandom_range(0, 1) ? next_exp : rand64(), 8'($urandom), 1'b0,
                            1'b1, 1'b0, 6'($urandom)));
      end else if (sel < 92) begin
        // no byte, no segment end: nothing happens
        send_item(make_item(rand64(), 8'($urandom), 1'b0, 1'b0, 1'($urandom), 6'($urandom)));
      end else if (sel < 96) begin
        // end index far ahead or wrapped to zero, so the stream stays open
        send_item(make_item(($urandom_range(0, 3) == 0) ? '1 : {1'b1, 63'(rand64())},
                            8'($urandom), 1'($urandom), 1'b1, 1'b1, 6'($urandom)));
      end else begin
        n = next_exp + $urandom_range(1, 8);
        send_item(make_item(n, 8'($urandom), 1'b1, 1'b0, 1'b0, 6'd32));
        send_item(make_item(n, 8'($urandom), 1'b1, 1'b0, 1'b0, 6'd32));
      end
    end
    idle_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_stream_close();
    logic [IDX_W-1:0] n;
    send_item(make_item('1, 8'h5e, 1'b1, 1'b1, 1'b1, 6'd32));
    // flush whatever is still stored so the end index lines up
    fill_window();
    n = next_exp;
    send_item(make_item(n + 1, 8'h01, 1'b1, 1'b0, 1'b0, 6'd32));
    send_item(make_item(n + 2, 8'h02, 1'b1, 1'b0, 1'b0, 6'd32));
    send_item(make_item(n + 3, 8'h03, 1'b1, 1'b1, 1'b1, 6'd32));
    // closes inside a run: earlier results still show the open state
    send_item(make_item(n, 8'h00, 1'b1, 1'b1, 1'b0, 6'd32));
    send_item(make_item(n + 4, 8'h04, 1'b1, 1'b1, 1'b0, 6'd32));
    send_item(make_item(n + 5, 8'h00, 1'b0, 1'b1, 1'b0, 6'd32));
    wait_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_segment();
    test_in_order();
    test_out_of_order();
    test_window_edges();
    test_overwrite();
    test_full_ring();
    test_backpressure();
    test_random_streams();
    test_stream_close();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (delivery_q.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, delivery_q.size());
      errors++;
    end
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t timeout, %0d results outstanding", $time, delivery_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
